FILE: hw/rtl/sfr_pkg.sv
package sfr_pkg;

    localparam logic [7:0] START_BYTE      = 8'hAA;
    localparam int         LEN_OVERHEAD    = 3;
    localparam int         MIN_FRAME_BYTES = 4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_LENGTH = 2'd1;
    localparam logic [1:0] ST_BAD_SUM    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       hunt_start;  // store start byte, open a frame
        logic       take_len;    // store length byte
        logic       take_data;   // store body or checksum byte
        logic       clear;       // back to hunting
        logic       rd;          // read frame store at emit index
        logic       load_ok;     // result register <- read data
        logic       load_err;    // result register <- error result
        logic [1:0] err_code;
        logic       idx_clr;
        logic       idx_inc;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_start;
        logic len_bad;
        logic frame_done;
        logic sum_ok;
        logic last_idx;
        logic out_valid;
        logic out_taken;
    } t_stat;

endpackage

FILE: hw/rtl/sfr_datapath.sv
module sfr_datapath #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_res_ready,
    input  sfr_pkg::t_cmd i_cmd,
    output sfr_pkg::t_stat o_stat,
    output logic          o_res_valid,
    output logic [7:0]    o_frame_byte,
    output logic [1:0]    o_status,
    output logic          o_is_last
);
    import sfr_pkg::*;

    localparam int AW = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    logic [7:0]    r_mem [MAX_FRAME_BYTES];
    logic [7:0]    r_rd;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_len, n_len;
    logic [7:0]    r_sum, n_sum;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic [1:0]    r_out_status;
    logic          r_out_last;

    logic [8:0]    total;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic          last_idx;

    assign total    = {1'b0, i_rx_byte} + 9'(LEN_OVERHEAD);
    assign wr_en    = i_cmd.hunt_start | i_cmd.take_len | i_cmd.take_data;
    assign last_idx = (CW'(r_idx) + CW'(1)) == r_len;

    always_comb begin
        if (i_cmd.hunt_start) begin
            wr_addr = '0;
        end else if (i_cmd.take_len) begin
            wr_addr = AW'(1);
        end else begin
            wr_addr = r_count[AW-1:0];
        end
    end

    // frame length is kept past the clear: the emit pass needs it for the last flag
    always_comb begin
        n_count = r_count;
        n_len   = r_len;
        n_sum   = r_sum;
        n_idx   = r_idx;
        if (i_cmd.clear) begin
            n_count = '0;
            n_sum   = '0;
        end else if (i_cmd.hunt_start) begin
            n_count = CW'(1);
            n_sum   = i_rx_byte;
        end else if (i_cmd.take_len) begin
            n_count = CW'(2);
            n_len   = total[CW-1:0];
            n_sum   = r_sum + i_rx_byte;
        end else if (i_cmd.take_data) begin
            n_count = r_count + CW'(1);
            n_sum   = r_sum + i_rx_byte;
        end
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            if (i_cmd.load_err || i_cmd.load_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_byte   <= 8'd0;
            r_out_status <= i_cmd.err_code;
            r_out_last   <= 1'b1;
        end else if (i_cmd.load_ok) begin
            r_out_byte   <= r_rd;
            r_out_status <= ST_OK;
            r_out_last   <= last_idx;
        end
    end

    // length byte of zero or a frame beyond the store is rejected
    assign o_stat.is_start   = i_rx_byte == START_BYTE;
    assign o_stat.len_bad    = (total < 9'(MIN_FRAME_BYTES)) || (total > 9'(MAX_FRAME_BYTES));
    assign o_stat.frame_done = (r_count + CW'(1)) == r_len;
    assign o_stat.sum_ok     = i_rx_byte == r_sum;
    assign o_stat.last_idx   = last_idx;
    assign o_stat.out_valid  = r_out_valid;
    assign o_stat.out_taken  = r_out_valid & i_res_ready;

    assign o_res_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_status     = r_out_status;
    assign o_is_last    = r_out_last;

endmodule

FILE: hw/rtl/sfr_ctrl.sv
module sfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rx_valid,
    input  sfr_pkg::t_stat i_stat,
    output logic           o_rx_ready,
    output sfr_pkg::t_cmd  o_cmd
);
    import sfr_pkg::*;

    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_DATA = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_LD   = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0] r_state, n_state;
    logic       rx_ready;
    logic       accept;

    // input is held off while a result waits in the output register
    assign rx_ready = ((r_state == S_HUNT) || (r_state == S_LEN) || (r_state == S_DATA))
                      && !i_stat.out_valid;
    assign accept   = rx_ready && i_rx_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (accept && i_stat.is_start) begin
                    o_cmd.hunt_start = 1'b1;
                    n_state          = S_LEN;
                end
            end
            S_LEN: begin
                if (accept) begin
                    if (i_stat.len_bad) begin
                        o_cmd.load_err = 1'b1;
                        o_cmd.err_code = ST_BAD_LENGTH;
                        o_cmd.clear    = 1'b1;
                        n_state        = S_HUNT;
                    end else begin
                        o_cmd.take_len = 1'b1;
                        n_state        = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (accept) begin
                    o_cmd.take_data = 1'b1;
                    if (i_stat.frame_done) begin
                        o_cmd.clear = 1'b1;
                        if (i_stat.sum_ok) begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_RD;
                        end else begin
                            o_cmd.load_err = 1'b1;
                            o_cmd.err_code = ST_BAD_SUM;
                            n_state        = S_HUNT;
                        end
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LD;
            end
            S_LD: begin
                o_cmd.load_ok = 1'b1;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                if (i_stat.out_taken) begin
                    if (i_stat.last_idx) begin
                        n_state = S_HUNT;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_rx_ready = rx_ready;

endmodule

FILE: hw/rtl/serial_frame_receiver_sum_check.sv
// Takes one byte per cycle while hunting or receiving a frame and no result is pending.
// Error result: valid the cycle after the request that causes it.
// Good frame: bytes are sent after the checksum byte, each one by a frame store read,
// a result load and a handoff; the next read waits until the sink takes the byte.
// No input is taken while a result is pending or a frame is being sent.
// Reset is synchronous, active low: back to hunting, no result pending.
module serial_frame_receiver_sum_check #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [7:0] o_frame_byte,
    output logic [1:0] o_status,
    output logic       o_is_last
);
    import sfr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_stat     (stat),
        .o_rx_ready (o_rx_ready),
        .o_cmd      (cmd)
    );

    sfr_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (i_rx_byte),
        .i_res_ready  (i_res_ready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_res_valid  (o_res_valid),
        .o_frame_byte (o_frame_byte),
        .o_status     (o_status),
        .o_is_last    (o_is_last)
    );

endmodule

FILE: hw/rtl/sfr_checker.sv
module sfr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_ready,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [7:0] o_frame_byte,
    input logic [1:0] o_status,
    input logic       o_is_last
);
    import sfr_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_frame_byte)
        && $stable(o_status) && $stable(o_is_last))
        else $error("result changed while stalled");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_status != ST_OK) |-> o_is_last && (o_frame_byte == 8'd0))
        else $error("error result not last or nonzero byte");

    a_no_rx_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !o_rx_ready)
        else $error("request taken while result pending");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind serial_frame_receiver_sum_check sfr_checker u_sfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_rx_ready   (o_rx_ready),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_frame_byte (o_frame_byte),
    .o_status     (o_status),
    .o_is_last    (o_is_last)
);
